/* rtl/dpt_pkg.sv */
package dpt_pkg;

  // Default sizing of the block.
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned VaddrBitsDef    = 48;
  localparam int unsigned FrameBitsDef    = 40;

  // Fixed register widths.
  localparam int unsigned HugeMinW  = 48;
  localparam int unsigned MaxPagesW = 37;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [MaxPagesW-1:0] MaxPagesRst = MaxPagesW'(262144);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHugeMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHugeMinVaddr = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxPages    = 2'd2;

  // Page size codes.
  localparam logic [1:0] Size4k = 2'd0;
  localparam logic [1:0] Size2m = 2'd1;
  localparam logic [1:0] Size1g = 2'd2;

  // Huge page mode codes.
  localparam logic [1:0] ModeOff = 2'd0;
  localparam logic [1:0] Mode2m  = 2'd1;

  // Address shifts and 4 KB frames per page for each size.
  localparam int unsigned Shift4k = 12;
  localparam int unsigned Shift2m = 21;
  localparam int unsigned Shift1g = 30;
  localparam int unsigned Ratio2m = 9;
  localparam int unsigned Ratio1g = 18;
  localparam int unsigned Per2m   = 512;
  localparam int unsigned Per1g   = 262144;

endpackage

/* rtl/dpt_ram.sv */
module dpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/demand_page_translator_core.sv */
// Demand page translator.
// A request beat is taken at a rising edge where start is high and busy is low; it carries
// vaddr_i and page_size_i (code 3 is served as 4 KB). The block looks the page number up in
// the table for that size and either returns the stored frame or allocates a new one from
// the global 4 KB frame counter, records it if the table has room and returns it.
// Exactly one result beat follows each request: done_o is high for one cycle with
// frame_number_o, hit_o, overcommit_o, table_full_o and policy_size_o. The receiver
// cannot stall, so the result is simply presented and gone in the next cycle.
// With an empty table the request goes straight to the allocation state; otherwise the
// search state runs first and ends in the result on a hit or in allocation on a miss:
// the single tag comparator walks the stored entries one per cycle through the table RAM,
// whose read is registered. busy is high from the accepting edge until the result shows,
// and a new request may be taken in the cycle the result is presented.
// Configuration writes through cfg_we_i / cfg_idx_i / cfg_data_i take effect at once; the
// user makes them while the block is idle, not enforced by the block. Reset empties all
// three tables, clears the frame counter and resets the registers; no clearing pass is needed.
module demand_page_translator_core #(
  parameter int unsigned TABLE_ENTRIES = dpt_pkg::TableEntriesDef,
  parameter int unsigned VADDR_BITS    = dpt_pkg::VaddrBitsDef,
  parameter int unsigned FRAME_BITS    = dpt_pkg::FrameBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [VADDR_BITS-1:0]       vaddr_i,
  input  logic [1:0]                  page_size_i,
  input  logic                        cfg_we_i,
  input  logic [dpt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dpt_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                        done_o,
  output logic [FRAME_BITS-1:0]       frame_number_o,
  output logic                        hit_o,
  output logic                        overcommit_o,
  output logic                        table_full_o,
  output logic [1:0]                  policy_size_o
);

  localparam int unsigned TagW   = VADDR_BITS - dpt_pkg::Shift4k;
  localparam int unsigned IdxW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RamD   = 3 * TABLE_ENTRIES;
  localparam int unsigned RamAW  = (RamD > 1) ? $clog2(RamD) : 1;
  localparam int unsigned RamW   = TagW + FRAME_BITS;
  localparam int unsigned SumW   = (FRAME_BITS + 1 > dpt_pkg::MaxPagesW) ?
                                   FRAME_BITS + 1 : dpt_pkg::MaxPagesW;
  localparam int unsigned CmpW   = (VADDR_BITS > dpt_pkg::HugeMinW) ?
                                   VADDR_BITS : dpt_pkg::HugeMinW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ALLOC
  } state_e;

  state_e                        state_q;
  logic [CntW-1:0]               idx_q;
  logic                          cmp_vld_q;
  logic [CntW-1:0]               cnt_4k_q, cnt_2m_q, cnt_1g_q;
  logic [FRAME_BITS-1:0]         nff_q;
  logic [1:0]                    huge_mode_q;
  logic [dpt_pkg::HugeMinW-1:0]  huge_min_q;
  logic [dpt_pkg::MaxPagesW-1:0] max_pages_q;
  logic                          done_q, hit_q, over_q, full_q;
  logic [FRAME_BITS-1:0]         frame_q;

  // Payload of the item in flight.
  logic [TagW-1:0]               vpn_q;
  logic [1:0]                    sz_q;
  logic [1:0]                    pol_q;

  logic [1:0]                    in_sz;
  logic [TagW-1:0]               in_vpn;
  logic [CntW-1:0]               in_cnt, cur_cnt;
  logic [1:0]                    in_pol;
  logic                          accept;
  logic [RamAW-1:0]              base, ram_addr;
  logic [CntW-1:0]               slot;
  logic [RamW-1:0]               rdata;
  logic                          tag_match, full;
  logic [SumW-1:0]               per_page, nff_sum;
  logic                          over;
  logic [FRAME_BITS-1:0]         frame_alloc;
  logic                          ram_we;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Request decode: page size code 3 is served as 4 KB.
  always_comb begin
    unique case (page_size_i)
      dpt_pkg::Size2m: begin
        in_sz  = dpt_pkg::Size2m;
        in_vpn = TagW'(vaddr_i >> dpt_pkg::Shift2m);
        in_cnt = cnt_2m_q;
      end
      dpt_pkg::Size1g: begin
        in_sz  = dpt_pkg::Size1g;
        in_vpn = TagW'(vaddr_i >> dpt_pkg::Shift1g);
        in_cnt = cnt_1g_q;
      end
      default: begin
        in_sz  = dpt_pkg::Size4k;
        in_vpn = TagW'(vaddr_i >> dpt_pkg::Shift4k);
        in_cnt = cnt_4k_q;
      end
    endcase
  end

  always_comb begin
    priority if (huge_mode_q == dpt_pkg::ModeOff) begin
      in_pol = dpt_pkg::Size4k;
    end else if (CmpW'(vaddr_i) < CmpW'(huge_min_q)) begin
      in_pol = dpt_pkg::Size4k;
    end else if (huge_mode_q == dpt_pkg::Mode2m) begin
      in_pol = dpt_pkg::Size2m;
    end else begin
      in_pol = dpt_pkg::Size1g;
    end
  end

  // Per-size view of the item in flight.
  always_comb begin
    unique case (sz_q)
      dpt_pkg::Size2m: begin
        cur_cnt     = cnt_2m_q;
        base        = RamAW'(TABLE_ENTRIES);
        per_page    = SumW'(dpt_pkg::Per2m);
        frame_alloc = nff_q >> dpt_pkg::Ratio2m;
      end
      dpt_pkg::Size1g: begin
        cur_cnt     = cnt_1g_q;
        base        = RamAW'(2 * TABLE_ENTRIES);
        per_page    = SumW'(dpt_pkg::Per1g);
        frame_alloc = nff_q >> dpt_pkg::Ratio1g;
      end
      default: begin
        cur_cnt     = cnt_4k_q;
        base        = '0;
        per_page    = SumW'(1);
        frame_alloc = nff_q;
      end
    endcase
  end

  // The one RAM port address serves the search reads and the allocation write.
  assign slot     = (state_q == ST_ALLOC) ? cur_cnt : idx_q;
  assign ram_addr = base + RamAW'(slot[IdxW-1:0]);
  assign full     = (cur_cnt >= CntW'(TABLE_ENTRIES));
  assign ram_we   = (state_q == ST_ALLOC) && !full;

  assign tag_match = (rdata[RamW-1:FRAME_BITS] == vpn_q);
  assign nff_sum   = SumW'(nff_q) + per_page;
  assign over      = nff_sum > SumW'(max_pages_q);

  dpt_ram #(
    .Width (RamW),
    .Depth (RamD)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i ({vpn_q, frame_alloc}),
    .raddr_i (ram_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      cnt_4k_q    <= '0;
      cnt_2m_q    <= '0;
      cnt_1g_q    <= '0;
      nff_q       <= '0;
      huge_mode_q <= dpt_pkg::ModeOff;
      huge_min_q  <= '0;
      max_pages_q <= dpt_pkg::MaxPagesRst;
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      over_q      <= 1'b0;
      full_q      <= 1'b0;
      frame_q     <= '0;
      vpn_q       <= '0;
      sz_q        <= dpt_pkg::Size4k;
      pol_q       <= dpt_pkg::Size4k;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dpt_pkg::RegHugeMode:     huge_mode_q <= cfg_data_i[1:0];
          dpt_pkg::RegHugeMinVaddr: huge_min_q  <= cfg_data_i[dpt_pkg::HugeMinW-1:0];
          dpt_pkg::RegMaxPages:     max_pages_q <= cfg_data_i[dpt_pkg::MaxPagesW-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            vpn_q     <= in_vpn;
            sz_q      <= in_sz;
            pol_q     <= in_pol;
            idx_q     <= '0;
            cmp_vld_q <= 1'b0;
            state_q   <= (in_cnt == '0) ? ST_ALLOC : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // Read data in this cycle belongs to the entry issued in the last one.
          if (cmp_vld_q && tag_match) begin
            frame_q <= rdata[FRAME_BITS-1:0];
            hit_q   <= 1'b1;
            over_q  <= 1'b0;
            full_q  <= 1'b0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (idx_q < cur_cnt) begin
            idx_q     <= idx_q + CntW'(1);
            cmp_vld_q <= 1'b1;
          end else begin
            state_q <= ST_ALLOC;
          end
        end
        ST_ALLOC: begin
          frame_q <= frame_alloc;
          hit_q   <= 1'b0;
          over_q  <= over;
          full_q  <= full;
          done_q  <= 1'b1;
          nff_q   <= nff_sum[FRAME_BITS-1:0];
          if (!full) begin
            unique case (sz_q)
              dpt_pkg::Size2m: cnt_2m_q <= cnt_2m_q + CntW'(1);
              dpt_pkg::Size1g: cnt_1g_q <= cnt_1g_q + CntW'(1);
              default:         cnt_4k_q <= cnt_4k_q + CntW'(1);
            endcase
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o         = done_q;
  assign frame_number_o = frame_q;
  assign hit_o          = hit_q;
  assign overcommit_o   = over_q;
  assign table_full_o   = full_q;
  assign policy_size_o  = pol_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while still busy");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted beat produced neither work nor a result");

  a_hit_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (!overcommit_o && !table_full_o))
    else $error("hit flagged overcommit or a full table");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_4k_q <= CntW'(TABLE_ENTRIES)) && (cnt_2m_q <= CntW'(TABLE_ENTRIES)) &&
    (cnt_1g_q <= CntW'(TABLE_ENTRIES)))
    else $error("table fill count beyond its depth");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TableEntries = dpt_pkg::TableEntriesDef;
  localparam int unsigned VaddrBitsDef = dpt_pkg::VaddrBitsDef;
  localparam int unsigned FrameBitsDef = dpt_pkg::FrameBitsDef;
  localparam int unsigned HugeMinW     = dpt_pkg::HugeMinW;
  localparam int unsigned MaxPagesW    = dpt_pkg::MaxPagesW;
  localparam int unsigned CfgIdxW      = dpt_pkg::CfgIdxW;
  localparam int unsigned CfgDataW     = dpt_pkg::CfgDataW;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned PhaseItems   = 186;
  localparam int unsigned PoolDepth    = 192;

  // Codes outside the package: the 1 GB mode and the two aliases the block accepts.
  localparam logic [1:0] Mode1g      = 2'd2;
  localparam logic [1:0] ModeAlias1g = 2'd3;
  localparam logic [1:0] SizeAlias4k = 2'd3;

  localparam logic [MaxPagesW-1:0] MaxPagesTop = MaxPagesW'(64'h10_0000_0000);

  typedef struct packed {
    logic [VaddrBitsDef-1:0] va;
    logic [1:0]              sz;
  } request_t;

  typedef struct packed {
    logic [FrameBitsDef-1:0] frame;
    logic                    hit;
    logic                    overcommit;
    logic                    table_full;
    logic [1:0]              policy;
  } translation_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  logic [VaddrBitsDef-1:0] vaddr_i     = '0;
  logic [1:0]              page_size_i = dpt_pkg::Size4k;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i   = dpt_pkg::RegHugeMode;
  logic [CfgDataW-1:0]     cfg_data_i  = '0;
  logic                    done_o;
  logic [FrameBitsDef-1:0] frame_number_o;
  logic                    hit_o;
  logic                    overcommit_o;
  logic                    table_full_o;
  logic [1:0]              policy_size_o;

  demand_page_translator_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .vaddr_i        (vaddr_i),
    .page_size_i    (page_size_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .frame_number_o (frame_number_o),
    .hit_o          (hit_o),
    .overcommit_o   (overcommit_o),
    .table_full_o   (table_full_o),
    .policy_size_o  (policy_size_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow of the block: registers, the three page tables and the frame counter.
  logic [1:0]              huge_mode_q  = dpt_pkg::ModeOff;
  logic [HugeMinW-1:0]     huge_min_q   = '0;
  logic [MaxPagesW-1:0]    max_pages_q  = dpt_pkg::MaxPagesRst;
  logic [VaddrBitsDef-1:0] page_tag   [3][TableEntries];
  logic [FrameBitsDef-1:0] page_frame [3][TableEntries];
  int unsigned             page_count [3] = '{0, 0, 0};
  logic [FrameBitsDef-1:0] free_frame = '0;

  request_t                request_queue[$];
  translation_t            expected_translations[$];
  logic [VaddrBitsDef-1:0] seen_vaddrs[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_left       = 0;
  int unsigned burst_left     = 0;
  bit          offered        = 1'b0;
  request_t    next_req;

  function automatic logic [VaddrBitsDef-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VaddrBitsDef-1:0];
  endfunction

  function automatic void translate_request(logic [VaddrBitsDef-1:0] va, logic [1:0] sz);
    translation_t            t;
    int unsigned             tbl;
    int unsigned             shift;
    int unsigned             ratio;
    logic [VaddrBitsDef-1:0] vpn;
    logic [63:0]             step;
    bit                      found;
    case (sz)
      dpt_pkg::Size2m: begin
        tbl = 1; shift = dpt_pkg::Shift2m; ratio = dpt_pkg::Ratio2m;
      end
      dpt_pkg::Size1g: begin
        tbl = 2; shift = dpt_pkg::Shift1g; ratio = dpt_pkg::Ratio1g;
      end
      default: begin
        tbl = 0; shift = dpt_pkg::Shift4k; ratio = 0;
      end
    endcase
    vpn = va >> shift;
    if (huge_mode_q == dpt_pkg::ModeOff || va < huge_min_q) t.policy = dpt_pkg::Size4k;
    else if (huge_mode_q == dpt_pkg::Mode2m) t.policy = dpt_pkg::Size2m;
    else t.policy = dpt_pkg::Size1g;
    found = 1'b0;
    t.frame = '0;
    for (int i = 0; i < page_count[tbl]; i++) begin
      if (!found && page_tag[tbl][i] == vpn) begin
        found = 1'b1;
        t.frame = page_frame[tbl][i];
      end
    end
    if (found) begin
      t.hit = 1'b1;
      t.overcommit = 1'b0;
      t.table_full = 1'b0;
    end else begin
      step = 64'd1 << ratio;
      t.hit = 1'b0;
      t.overcommit = (64'(free_frame) + step) > 64'(max_pages_q);
      t.frame = free_frame >> ratio;
      free_frame = free_frame + FrameBitsDef'(step);
      t.table_full = page_count[tbl] >= TableEntries;
      if (!t.table_full) begin
        page_tag[tbl][page_count[tbl]] = vpn;
        page_frame[tbl][page_count[tbl]] = t.frame;
        page_count[tbl]++;
      end
    end
    expected_translations.push_back(t);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Often revisits pages seen early on, so that hits keep coming once the tables fill.
  function automatic request_t make_request();
    request_t                r;
    int unsigned             pick;
    int unsigned             shift;
    logic [VaddrBitsDef-1:0] low_mask;
    logic [VaddrBitsDef-1:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.sz = dpt_pkg::Size4k;
    else if (pick < 65) r.sz = dpt_pkg::Size2m;
    else if (pick < 95) r.sz = dpt_pkg::Size1g;
    else r.sz = SizeAlias4k;
    shift = (r.sz == dpt_pkg::Size2m) ? dpt_pkg::Shift2m :
            (r.sz == dpt_pkg::Size1g) ? dpt_pkg::Shift1g : dpt_pkg::Shift4k;
    low_mask = (VaddrBitsDef'(1) << shift) - VaddrBitsDef'(1);
    pick = $urandom_range(0, 99);
    if (pick < 45 && seen_vaddrs.size() != 0) begin
      base = seen_vaddrs[$urandom_range(0, seen_vaddrs.size() - 1)];
      r.va = (base & ~low_mask) | (rand48() & low_mask);
    end else if (pick < 55) begin
      r.va = huge_min_q - VaddrBitsDef'(4) + VaddrBitsDef'($urandom_range(0, 8));
    end else if (pick < 62) begin
      base = $urandom_range(0, 1) ? '1 : '0;
      r.va = (base & ~low_mask) | (rand48() & low_mask);
    end else begin
      r.va = rand48();
    end
    if (seen_vaddrs.size() < PoolDepth) seen_vaddrs.push_back(r.va);
    return r;
  endfunction

  function automatic void queue_request(logic [VaddrBitsDef-1:0] va, logic [1:0] sz);
    request_t r;
    r.va = va;
    r.sz = sz;
    request_queue.push_back(r);
  endfunction

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // Request driver: an offered beat stays on the port until the block takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      vaddr_i <= '0;
      page_size_i <= dpt_pkg::Size4k;
      offered = 1'b0;
      gap_left = 0;
    end else begin
      if (offered && !busy) begin
        translate_request(vaddr_i, page_size_i);
        offered = 1'b0;
        gap_left = pick_gap();
      end
      if (!offered) begin
        if (gap_left == 0 && request_queue.size() != 0) begin
          next_req = request_queue.pop_front();
          start <= 1'b1;
          vaddr_i <= next_req.va;
          page_size_i <= next_req.sz;
          offered = 1'b1;
        end else begin
          if (gap_left != 0) gap_left--;
          start <= 1'b0;
          vaddr_i <= rand48();
          page_size_i <= 2'($urandom);
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    translation_t t;
    if (rst_ni && done_o) begin
      if (expected_translations.size() == 0) begin
        note_mismatch($sformatf("result beat with nothing expected, frame %0h",
                                frame_number_o));
      end else begin
        t = expected_translations.pop_front();
        if (frame_number_o !== t.frame || hit_o !== t.hit ||
            overcommit_o !== t.overcommit || table_full_o !== t.table_full ||
            policy_size_o !== t.policy) begin
          note_mismatch($sformatf(
            "expected frame %0h hit %0b over %0b full %0b policy %0d, got %0h %0b %0b %0b %0d",
            t.frame, t.hit, t.overcommit, t.table_full, t.policy, frame_number_o, hit_o,
            overcommit_o, table_full_o, policy_size_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dpt_pkg::RegHugeMode:     huge_mode_q = data[1:0];
      dpt_pkg::RegHugeMinVaddr: huge_min_q = data[HugeMinW-1:0];
      dpt_pkg::RegMaxPages:     max_pages_q = data[MaxPagesW-1:0];
      default: ;
    endcase
  endtask

  // Checked at the falling edge so that the driver and monitor have settled.
  task automatic wait_until_quiet();
    @(negedge clk_i);
    while (request_queue.size() != 0 || offered || expected_translations.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    logic [1:0]           mode;
    logic [HugeMinW-1:0]  min_va;
    logic [MaxPagesW-1:0] cap;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at their reset values.
    queue_request(48'h0, dpt_pkg::Size4k);
    queue_request(48'hFFF, dpt_pkg::Size4k);
    queue_request(48'h0, dpt_pkg::Size2m);         // counter at one frame truncates to 0
    queue_request(48'h1F_FFFF, dpt_pkg::Size2m);
    queue_request(48'hFFFF_FFFF_FFFF, dpt_pkg::Size1g);
    queue_request(48'h0, dpt_pkg::Size1g);         // also beyond the default capacity
    queue_request(48'h1000, SizeAlias4k);
    queue_request(48'h1ABC, dpt_pkg::Size4k);      // hits the entry stored through code 3
    queue_request(48'hFFFF_FFFF_FFFF, dpt_pkg::Size4k);
    queue_request(48'hFFFF_FFFF_F000, SizeAlias4k);
    queue_request(48'hFFFF_FFE0_0000, dpt_pkg::Size2m);
    queue_request(48'hAAAA_AAAA_AAAA, dpt_pkg::Size4k);
    queue_request(48'h5555_5555_5555, dpt_pkg::Size2m);
    wait_until_quiet();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          mode = dpt_pkg::Mode2m; min_va = '0; cap = '0;
        end
        1: begin
          mode = Mode1g; min_va = '1; cap = MaxPagesTop;
        end
        2: begin
          mode = ModeAlias1g; min_va = rand48();
          cap = MaxPagesW'(free_frame) + MaxPagesW'($urandom_range(0, 600000));
        end
        3: begin
          mode = dpt_pkg::ModeOff; min_va = rand48(); cap = MaxPagesTop;
        end
        default: begin
          mode = 2'($urandom_range(0, 3));
          min_va = $urandom_range(0, 1) ? rand48() : '0;
          cap = MaxPagesW'(free_frame) + MaxPagesW'($urandom_range(0, 1 << 20));
        end
      endcase
      write_reg(dpt_pkg::RegHugeMode, CfgDataW'(mode));
      write_reg(dpt_pkg::RegHugeMinVaddr, CfgDataW'(min_va));
      write_reg(dpt_pkg::RegMaxPages, CfgDataW'(cap));
      @(negedge clk_i);
      for (int n = 0; n < PhaseItems; n++) request_queue.push_back(make_request());
      wait_until_quiet();
    end

    repeat (TableEntries + 8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_translations.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
